// File: sv/sliding_window_maximum_defines.svh
// Assertion macros for the sliding window maximum RTL.
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/swm_pkg.sv
`default_nettype none
package swm_pkg;

	localparam int DEPTH    = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = IDX_W + 1;
	localparam int POS_W    = IDX_W + 1;
	localparam int SAMPLE_W = 16;
	localparam int WIN_W    = 7;

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(3);

	typedef struct packed {
		logic load;
		logic rd_back;
		logic drop_head;
		logic drop_tail;
		logic write;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic expired;
		logic smaller;
		logic emit;
	} status_t;

endpackage
`default_nettype wire

// File: sv/sliding_window_maximum.sv
// Sliding window maximum over a deque of candidates kept in a 64-entry memory.
// Each accepted beat reads the front of the deque, dropping expired candidates, then reads the
// back, dropping smaller ones, appends the sample and reads the front again for the result.
// Flow: a new beat is accepted only while the block is idle, once out_valid rises or, while the
// window is still filling, after the append; a stalled result holds the block until it is loaded.
// Reset: arst_n clears the deque, fill count, position and sets the window to 3.
`default_nettype none
module sliding_window_maximum (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                window_size_we,
	input  wire logic [swm_pkg::WIN_W-1:0]           window_size,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                start_req,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic signed [swm_pkg::SAMPLE_W-1:0]      window_max
);
	import swm_pkg::*;

	cmd_t    cmd;
	status_t status;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	swm_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.window_size_we (window_size_we),
		.window_size    (window_size),
		.sample         (sample),
		.start_req      (start_req),
		.cmd            (cmd),
		.status         (status),
		.window_max     (window_max)
	);

endmodule
`default_nettype wire

// File: sv/swm_dp.sv
`default_nettype none
`include "sliding_window_maximum_defines.svh"
module swm_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           window_size_we,
	input  wire logic [swm_pkg::WIN_W-1:0]      window_size,
	input  wire logic signed [swm_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                           start_req,
	input  wire swm_pkg::cmd_t                  cmd,
	output swm_pkg::status_t                    status,
	output logic signed [swm_pkg::SAMPLE_W-1:0] window_max
);
	import swm_pkg::*;

	localparam int ENTRY_W = SAMPLE_W + POS_W;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rdata_q;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   wr_addr;

	logic [WIN_W-1:0]    window_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    head_q;
	logic [POS_W-1:0]    pos_q;
	logic [CNT_W-1:0]    fill_q;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic [WIN_W-1:0]    win_eff;
	logic [POS_W-1:0]    age;
	logic signed [SAMPLE_W-1:0] rd_value;
	logic [POS_W-1:0]    rd_pos;
	logic                full;
	logic                any_drop;

	// Zero is read as a window of one; anything past the depth saturates.
	always_comb begin
		if (window_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (window_q > WIN_W'(DEPTH)) begin
			win_eff = WIN_W'(DEPTH);
		end else begin
			win_eff = window_q;
		end
	end

	assign rd_value = rdata_q[SAMPLE_W-1:0];
	assign rd_pos   = rdata_q[ENTRY_W-1:SAMPLE_W];
	// Positions wrap at twice the depth, so the age is a plain wrapping subtract.
	assign age      = pos_q - rd_pos;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign any_drop = cmd.drop_head | cmd.drop_tail;

	assign status.count_zero = (count_q == '0);
	assign status.expired    = ({1'b0, age} >= {1'b0, win_eff});
	assign status.smaller    = (rd_value < sample_q);
	assign status.emit       = ({1'b0, fill_q} >= {1'b0, win_eff});

	always_comb begin
		if (cmd.rd_back) begin
			rd_addr = head_q + count_q[IDX_W-1:0] - IDX_W'(1);
		end else begin
			rd_addr = head_q;
		end
	end

	// When the deque is full the front is dropped and its slot reused, which
	// lands on the same address as the usual tail slot.
	assign wr_addr = head_q + count_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_addr] <= {pos_q, sample_q};
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_RESET;
		end else if (window_size_we) begin
			window_q <= window_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
			pos_q   <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.load && start_req) begin
				count_q <= '0;
				head_q  <= '0;
				pos_q   <= '0;
				fill_q  <= '0;
			end
			if (cmd.drop_head) begin
				head_q  <= head_q + IDX_W'(1);
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.drop_tail) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.write) begin
				if (full) begin
					head_q <= head_q + IDX_W'(1);
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				if (!fill_q[CNT_W-1]) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		if (cmd.load_out) begin
			window_max <= rd_value;
		end
	end

	`SWM_ASSERT_IMPLIES(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH), "count past depth")
	`SWM_ASSERT_IMPLIES(a_fill_range, clk, arst_n, 1'b1, fill_q <= CNT_W'(DEPTH), "fill past depth")
	`SWM_ASSERT_IMPLIES(a_pop_nonempty, clk, arst_n, any_drop, count_q != '0, "pop from empty deque")
	`SWM_ASSERT_NEXT(a_write_nonempty, clk, arst_n, cmd.write, count_q != '0, "empty after append")

endmodule
`default_nettype wire

// File: sv/swm_ctrl.sv
`default_nettype none
module swm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire swm_pkg::status_t  status,
	output swm_pkg::cmd_t          cmd
);
	import swm_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_F_RD  = 3'd1;
	localparam logic [2:0] S_F_CHK = 3'd2;
	localparam logic [2:0] S_B_RD  = 3'd3;
	localparam logic [2:0] S_B_CHK = 3'd4;
	localparam logic [2:0] S_WR    = 3'd5;
	localparam logic [2:0] S_O_RD  = 3'd6;
	localparam logic [2:0] S_O_OUT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_F_RD;
				end
			end
			S_F_RD: begin
				if (status.count_zero) begin
					state_d = S_B_RD;
				end else begin
					state_d = S_F_CHK;
				end
			end
			S_F_CHK: begin
				if (status.expired) begin
					cmd.drop_head = 1'b1;
					state_d       = S_F_RD;
				end else begin
					state_d = S_B_RD;
				end
			end
			S_B_RD: begin
				if (status.count_zero) begin
					state_d = S_WR;
				end else begin
					cmd.rd_back = 1'b1;
					state_d     = S_B_CHK;
				end
			end
			S_B_CHK: begin
				if (status.smaller) begin
					cmd.drop_tail = 1'b1;
					state_d       = S_B_RD;
				end else begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				cmd.write = 1'b1;
				state_d   = S_O_RD;
			end
			S_O_RD: begin
				state_d = status.emit ? S_O_OUT : S_IDLE;
			end
			S_O_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire
